// ----- rtl/core/bwc_pkg.sv -----
`timescale 1ns / 1ps

package bwc_pkg;

    // default sizes
    localparam int LOG_MAX_LEN_DEF = 6;
    localparam int ELEM_WIDTH_DEF  = 16;

    // fixed field and register widths
    localparam int RES_W     = 44;
    localparam int MODE_W    = 2;
    localparam int LOG_LEN_W = 3;
    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    // op_mode codes
    localparam logic [MODE_W-1:0] MODE_AND = 2'd0;
    localparam logic [MODE_W-1:0] MODE_OR  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_XOR = 2'd2;

    // register indexes (paddr[2])
    localparam logic REG_OP_MODE = 1'b0;
    localparam logic REG_LOG_LEN = 1'b1;

    // reset values
    localparam logic [MODE_W-1:0]    MODE_RESET    = MODE_XOR;
    localparam logic [LOG_LEN_W-1:0] LOG_LEN_RESET = 3'd6;

    // shared arithmetic unit operations
    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL
    } alu_op_t;

    // configuration seen by the datapath
    typedef struct packed {
        logic [MODE_W-1:0]    mode;
        logic [LOG_LEN_W-1:0] lg;
        logic                 restart;
    } cfg_t;

endpackage

// ----- rtl/core/bwc_if.sv -----
`timescale 1ns / 1ps

// input channel: one element pair per transfer
interface bwc_in_if #(
    parameter int ELEM_W = 16
) ();
    logic                     valid;
    logic                     ready;
    logic signed [ELEM_W-1:0] a_elem;
    logic signed [ELEM_W-1:0] b_elem;

    modport source (output valid, output a_elem, output b_elem, input ready);
    modport sink   (input valid, input a_elem, input b_elem, output ready);
endinterface

// result channel: one convolution value per transfer
interface bwc_out_if import bwc_pkg::*; #(
    parameter int LOG_MAX = 6
) ();
    logic                    valid;
    logic                    ready;
    logic signed [RES_W-1:0] result_value;
    logic [LOG_MAX-1:0]      result_index;
    logic                    last_flag;

    modport source (output valid, output result_value, output result_index,
                    output last_flag, input ready);
    modport sink   (input valid, input result_value, input result_index,
                    input last_flag, output ready);
endinterface

// ----- rtl/core/bwc_alu.sv -----
`timescale 1ns / 1ps

module bwc_alu import bwc_pkg::*; #(
    parameter int DATA_W = 22,
    parameter int ACC_W  = 49
) (
    input  alu_op_t                 op,
    input  logic signed [ACC_W-1:0] opa,
    input  logic signed [ACC_W-1:0] opb,
    output logic signed [ACC_W-1:0] res
);

    logic signed [DATA_W-1:0]   mul_a;
    logic signed [DATA_W-1:0]   mul_b;
    logic signed [2*DATA_W-1:0] prod;

    // multiplier operands are the transformed elements
    assign mul_a = opa[DATA_W-1:0];
    assign mul_b = opb[DATA_W-1:0];
    assign prod  = mul_a * mul_b;

    // add, subtract or multiply
    always_comb
    begin
        unique case (op)
            ALU_ADD: res = opa + opb;
            ALU_SUB: res = opa - opb;
            ALU_MUL: res = ACC_W'(prod);
            default: res = opa;
        endcase
    end

endmodule

// ----- rtl/core/bwc_core.sv -----
`timescale 1ns / 1ps

module bwc_core import bwc_pkg::*; #(
    parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF,
    parameter int LOG_MAX_LEN = LOG_MAX_LEN_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  cfg_t           cfg,
    bwc_in_if.sink         in_ch,
    bwc_out_if.source      out_ch
);

    localparam int N_MAX  = 1 << LOG_MAX_LEN;
    localparam int DATA_W = ELEM_WIDTH + LOG_MAX_LEN;
    localparam int ACC_W  = 2 * DATA_W + LOG_MAX_LEN - 1;
    localparam int IDX_W  = LOG_MAX_LEN;
    localparam int CNT_W  = LOG_MAX_LEN + 1;

    typedef enum logic [2:0] {
        S_LOAD,
        S_BF_RD,
        S_BF_WX,
        S_BF_WY,
        S_MUL_RD,
        S_MUL_WR,
        S_EMIT_RD,
        S_EMIT_OUT
    } state_t;

    typedef enum logic [1:0] {
        PASS_A_FWD,
        PASS_B_FWD,
        PASS_A_INV
    } pass_t;

    state_t                   state_reg;
    pass_t                    pass_reg;
    logic [LOG_LEN_W-1:0]     stage_reg;
    logic [IDX_W-1:0]         pair_reg;
    logic [CNT_W-1:0]         cnt_reg;

    logic                     out_valid_reg;
    logic signed [RES_W-1:0]  out_value_reg;
    logic [IDX_W-1:0]         out_index_reg;
    logic                     out_last_reg;

    // working stores
    logic signed [ACC_W-1:0]  a_mem [N_MAX];
    logic signed [DATA_W-1:0] b_mem [N_MAX];
    logic signed [ACC_W-1:0]  ax_reg;
    logic signed [ACC_W-1:0]  ay_reg;
    logic signed [DATA_W-1:0] bx_reg;
    logic signed [DATA_W-1:0] by_reg;

    logic [CNT_W-1:0]         n_len;
    logic [CNT_W-1:0]         half_m1;
    logic [CNT_W-1:0]         last_k;
    logic [IDX_W-1:0]         low_mask;
    logic [IDX_W-1:0]         lo_addr;
    logic [IDX_W-1:0]         hi_addr;
    logic [IDX_W-1:0]         k_idx;
    logic                     is_and;
    logic                     is_or;
    logic                     is_xor;
    logic                     inv;
    logic                     in_xfer;
    logic                     out_free;
    logic                     pair_last;
    logic                     stage_last;
    logic                     rd_en;
    logic [IDX_W-1:0]         rd_x_addr;

    alu_op_t                  alu_op;
    logic signed [ACC_W-1:0]  x_val;
    logic signed [ACC_W-1:0]  y_val;
    logic signed [ACC_W-1:0]  alu_a;
    logic signed [ACC_W-1:0]  alu_b;
    logic signed [ACC_W-1:0]  alu_res;
    logic signed [ACC_W-1:0]  shifted;

    logic                     a_we;
    logic [IDX_W-1:0]         a_waddr;
    logic signed [ACC_W-1:0]  a_wdata;
    logic                     b_we;
    logic [IDX_W-1:0]         b_waddr;
    logic signed [DATA_W-1:0] b_wdata;

    // length and mode decode
    assign n_len   = CNT_W'(1) << cfg.lg;
    assign half_m1 = (n_len >> 1) - CNT_W'(1);
    assign last_k  = n_len - CNT_W'(1);
    assign is_and  = (cfg.mode == MODE_AND);
    assign is_or   = (cfg.mode == MODE_OR);
    assign is_xor  = !is_and && !is_or;
    assign inv     = (pass_reg == PASS_A_INV);
    assign k_idx   = cnt_reg[IDX_W-1:0];

    // butterfly pair addresses: insert a zero at the stage bit
    assign low_mask   = (IDX_W'(1) << stage_reg) - IDX_W'(1);
    assign lo_addr    = IDX_W'((pair_reg & ~low_mask) << 1) | (pair_reg & low_mask);
    assign hi_addr    = lo_addr | (IDX_W'(1) << stage_reg);
    assign pair_last  = (CNT_W'(pair_reg) == half_m1);
    assign stage_last = (stage_reg == cfg.lg - LOG_LEN_W'(1));

    // handshakes
    assign in_ch.ready = (state_reg == S_LOAD);
    assign in_xfer     = in_ch.valid && (state_reg == S_LOAD);
    assign out_free    = !out_valid_reg || out_ch.ready;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.result_value = out_value_reg;
    assign out_ch.result_index = out_index_reg;
    assign out_ch.last_flag    = out_last_reg;

    // operand selection for the shared unit
    assign x_val = (pass_reg == PASS_B_FWD) ? ACC_W'(bx_reg) : ax_reg;
    assign y_val = (pass_reg == PASS_B_FWD) ? ACC_W'(by_reg) : ay_reg;

    always_comb
    begin
        alu_op = ALU_ADD;
        alu_a  = x_val;
        alu_b  = y_val;
        unique case (state_reg)
            S_BF_WX:
            begin
                alu_op = (is_and && inv) ? ALU_SUB : ALU_ADD;
            end
            S_BF_WY:
            begin
                if (is_or)
                begin
                    alu_a  = y_val;
                    alu_b  = x_val;
                    alu_op = inv ? ALU_SUB : ALU_ADD;
                end
                else
                begin
                    alu_op = ALU_SUB;
                end
            end
            S_MUL_WR:
            begin
                alu_op = ALU_MUL;
                alu_a  = ax_reg;
                alu_b  = ACC_W'(bx_reg);
            end
            default:
            begin
                alu_op = ALU_ADD;
            end
        endcase
    end

    bwc_alu #(
        .DATA_W (DATA_W),
        .ACC_W  (ACC_W)
    ) u_alu (
        .op  (alu_op),
        .opa (alu_a),
        .opb (alu_b),
        .res (alu_res)
    );

    // store write port selection
    always_comb
    begin
        a_we    = 1'b0;
        a_waddr = k_idx;
        a_wdata = alu_res;
        b_we    = 1'b0;
        b_waddr = k_idx;
        b_wdata = alu_res[DATA_W-1:0];
        unique case (state_reg)
            S_LOAD:
            begin
                // keep the low element bits, sign-extended
                a_we    = in_xfer;
                a_wdata = ACC_W'($signed(in_ch.a_elem[ELEM_WIDTH-1:0]));
                b_we    = in_xfer;
                b_wdata = DATA_W'($signed(in_ch.b_elem[ELEM_WIDTH-1:0]));
            end
            S_BF_WX:
            begin
                a_waddr = lo_addr;
                b_waddr = lo_addr;
                a_we    = !is_or && (pass_reg != PASS_B_FWD);
                b_we    = !is_or && (pass_reg == PASS_B_FWD);
            end
            S_BF_WY:
            begin
                a_waddr = hi_addr;
                b_waddr = hi_addr;
                a_we    = !is_and && (pass_reg != PASS_B_FWD);
                b_we    = !is_and && (pass_reg == PASS_B_FWD);
            end
            S_MUL_WR:
            begin
                a_we = 1'b1;
            end
            default:
            begin
                a_we = 1'b0;
            end
        endcase
    end

    // read port control
    assign rd_en     = (state_reg == S_BF_RD) || (state_reg == S_MUL_RD) ||
                       (state_reg == S_EMIT_RD);
    assign rd_x_addr = (state_reg == S_BF_RD) ? lo_addr : k_idx;

    // first store
    always_ff @(posedge clk)
    begin
        if (a_we)
        begin
            a_mem[a_waddr] <= a_wdata;
        end
        if (rd_en)
        begin
            ax_reg <= a_mem[rd_x_addr];
            ay_reg <= a_mem[hi_addr];
        end
    end

    // second store
    always_ff @(posedge clk)
    begin
        if (b_we)
        begin
            b_mem[b_waddr] <= b_wdata;
        end
        if (rd_en)
        begin
            bx_reg <= b_mem[rd_x_addr];
            by_reg <= b_mem[hi_addr];
        end
    end

    // xor inverse divides by the length
    assign shifted = is_xor ? (ax_reg >>> cfg.lg) : ax_reg;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            pass_reg      <= PASS_A_FWD;
            stage_reg     <= '0;
            pair_reg      <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_value_reg <= '0;
            out_index_reg <= '0;
            out_last_reg  <= 1'b0;
        end
        else
        begin
            // output transfer done, unless a new result is loaded below
            if (out_valid_reg && out_ch.ready && (state_reg != S_EMIT_OUT))
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_LOAD:
                begin
                    if (cfg.restart)
                    begin
                        cnt_reg <= '0;
                    end
                    else if (in_xfer)
                    begin
                        if (cnt_reg == last_k)
                        begin
                            cnt_reg   <= '0;
                            pass_reg  <= PASS_A_FWD;
                            stage_reg <= '0;
                            pair_reg  <= '0;
                            state_reg <= (cfg.lg == '0) ? S_MUL_RD : S_BF_RD;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + CNT_W'(1);
                        end
                    end
                end
                S_BF_RD:
                begin
                    state_reg <= S_BF_WX;
                end
                S_BF_WX:
                begin
                    state_reg <= S_BF_WY;
                end
                S_BF_WY:
                begin
                    if (!pair_last)
                    begin
                        state_reg <= S_BF_RD;
                        pair_reg  <= pair_reg + IDX_W'(1);
                    end
                    else
                    begin
                        pair_reg <= '0;
                        if (!stage_last)
                        begin
                            state_reg <= S_BF_RD;
                            stage_reg <= stage_reg + LOG_LEN_W'(1);
                        end
                        else
                        begin
                            stage_reg <= '0;
                            unique case (pass_reg)
                                PASS_A_FWD:
                                begin
                                    pass_reg  <= PASS_B_FWD;
                                    state_reg <= S_BF_RD;
                                end
                                PASS_B_FWD:
                                begin
                                    cnt_reg   <= '0;
                                    state_reg <= S_MUL_RD;
                                end
                                default:
                                begin
                                    cnt_reg   <= '0;
                                    state_reg <= S_EMIT_RD;
                                end
                            endcase
                        end
                    end
                end
                S_MUL_RD:
                begin
                    state_reg <= S_MUL_WR;
                end
                S_MUL_WR:
                begin
                    if (cnt_reg == last_k)
                    begin
                        cnt_reg <= '0;
                        if (cfg.lg == '0)
                        begin
                            state_reg <= S_EMIT_RD;
                        end
                        else
                        begin
                            pass_reg  <= PASS_A_INV;
                            state_reg <= S_BF_RD;
                        end
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + CNT_W'(1);
                        state_reg <= S_MUL_RD;
                    end
                end
                S_EMIT_RD:
                begin
                    state_reg <= S_EMIT_OUT;
                end
                S_EMIT_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_value_reg <= RES_W'(shifted);
                        out_index_reg <= k_idx;
                        out_last_reg  <= (cnt_reg == last_k);
                        if (cnt_reg == last_k)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= S_LOAD;
                        end
                        else
                        begin
                            cnt_reg   <= cnt_reg + CNT_W'(1);
                            state_reg <= S_EMIT_RD;
                        end
                    end
                end
                default:
                begin
                    state_reg <= S_LOAD;
                end
            endcase
        end
    end

`ifndef SYNTH
    // the two halves of a butterfly never share an address
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_BF_RD) |-> (lo_addr != hi_addr))
        else $error("butterfly pair addresses collide");

    // the load count stays inside the current length
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LOAD) |-> (cnt_reg < n_len))
        else $error("load count beyond sequence length");

    // the final result of a run carries the top index
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_last_reg) |-> (CNT_W'(out_index_reg) == last_k))
        else $error("last flag on wrong index");

    // loading the final result returns the block to loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT_OUT && out_free && cnt_reg == last_k)
        |=> (state_reg == S_LOAD && out_valid_reg && out_last_reg))
        else $error("run did not end after last result");
`endif

endmodule

// ----- rtl/core/bitwise_and_or_xor_convolution.sv -----
`timescale 1ns / 1ps

// channel   | role   | handshake      | payload
// ----------+--------+----------------+------------------------------------------
// in_ch     | sink   | valid / ready  | a_elem, b_elem (signed ELEM_WIDTH)
// out_ch    | source | valid / ready  | result_value (44), result_index, last_flag
// apb       | slave  | psel / penable | op_mode @ 0x0, log_length @ 0x4, pready = 1
//
// while loading, one pair is taken per cycle, N = 2^min(log_length, LOG_MAX_LEN) pairs per run
// after the last pair the block is busy: every butterfly steps through read, write-x
// and write-y states on the single adder and single store write port, each product through
// read and write states, each result through read and output states plus any wait on out_ch.ready
// the last result may still wait in the output register while the next run loads
// reset: op_mode = xor, log_length = 6, load count cleared; a log_length write restarts loading

module bitwise_and_or_xor_convolution import bwc_pkg::*; #(
    parameter int ELEM_WIDTH  = ELEM_WIDTH_DEF,
    parameter int LOG_MAX_LEN = LOG_MAX_LEN_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    bwc_in_if.sink             in_ch,
    bwc_out_if.source          out_ch,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [MODE_W-1:0]    mode_reg;
    logic [LOG_LEN_W-1:0] log_len_reg;
    logic [LOG_LEN_W-1:0] lg_eff;
    logic                 reg_sel;
    logic                 wr_xfer;
    cfg_t                 cfg;

    assign pready  = 1'b1;
    assign reg_sel = paddr[2];
    assign wr_xfer = psel && penable && pwrite;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_RESET;
            log_len_reg <= LOG_LEN_RESET;
        end
        else if (wr_xfer)
        begin
            unique case (reg_sel)
                REG_OP_MODE: mode_reg    <= pwdata[MODE_W-1:0];
                REG_LOG_LEN: log_len_reg <= pwdata[LOG_LEN_W-1:0];
                default:     mode_reg    <= mode_reg;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        unique case (reg_sel)
            REG_OP_MODE: prdata = PDATA_W'(mode_reg);
            REG_LOG_LEN: prdata = PDATA_W'(log_len_reg);
            default:     prdata = '0;
        endcase
    end

    // clamp the length to the store depth
    assign lg_eff = (log_len_reg > LOG_LEN_W'(LOG_MAX_LEN)) ?
                    LOG_LEN_W'(LOG_MAX_LEN) : log_len_reg;

    assign cfg.mode    = mode_reg;
    assign cfg.lg      = lg_eff;
    assign cfg.restart = wr_xfer && (reg_sel == REG_LOG_LEN);

    bwc_core #(
        .ELEM_WIDTH  (ELEM_WIDTH),
        .LOG_MAX_LEN (LOG_MAX_LEN)
    ) u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

endmodule

// ----- test/conv_check_pkg.sv -----
`timescale 1ns / 1ps

package conv_check_pkg;
    import bwc_pkg::*;

    localparam int MAX_LOG     = LOG_MAX_LEN_DEF;
    localparam int MAX_LEN     = 1 << MAX_LOG;
    localparam int ELEM_W      = ELEM_WIDTH_DEF;

    // one convolution output as the block should send it
    typedef struct {
        logic [RES_W-1:0]   value;
        logic [MAX_LOG-1:0] index;
        logic               last;
    } coeff_t;

    // butterfly flavors: superset sums for and, subset sums for or, hadamard for xor
    typedef enum int {
        SUPERSET_SUM,
        SUPERSET_DIFF,
        SUBSET_SUM,
        SUBSET_DIFF,
        HADAMARD
    } xform_t;

    class conv_scoreboard;
        logic [MODE_W-1:0]    mode;
        logic [LOG_LEN_W-1:0] log_len;
        int                   loaded;
        logic [63:0]          a_work [MAX_LEN];
        logic [63:0]          b_work [MAX_LEN];
        coeff_t               expected_coeffs [$];
        int                   mismatches;

        function new();
            mode       = MODE_RESET;
            log_len    = LOG_LEN_RESET;
            loaded     = 0;
            mismatches = 0;
            foreach (a_work[i])
            begin
                a_work[i] = '0;
                b_work[i] = '0;
            end
        endfunction

        // lengths above the supported maximum are clamped
        function int eff_log();
            return (log_len > MAX_LOG) ? MAX_LOG : int'(log_len);
        endfunction

        function int run_length();
            return 1 << eff_log();
        endfunction

        function int pending();
            return expected_coeffs.size();
        endfunction

        // a log_length write restarts loading, an op_mode write does not
        function void write_register(logic reg_sel, logic [PDATA_W-1:0] value);
            if (reg_sel == REG_OP_MODE)
            begin
                mode = value[MODE_W-1:0];
            end
            else
            begin
                log_len = value[LOG_LEN_W-1:0];
                loaded  = 0;
            end
        endfunction

        // in-place butterfly transform over the first n entries, 64-bit wraparound
        function void transform(inout logic [63:0] v [MAX_LEN], input int n,
                                input xform_t kind);
            int          h;
            int          j;
            logic [63:0] x;
            logic [63:0] y;
            logic [63:0] t;
            for (h = 1; h < n; h = h << 1)
            begin
                for (j = 0; j < n; j++)
                begin
                    if ((j & h) != 0)
                    begin
                        x = v[j ^ h];
                        y = v[j];
                        case (kind)
                            SUPERSET_SUM:  x = x + y;
                            SUPERSET_DIFF: x = x - y;
                            SUBSET_SUM:    y = x + y;
                            SUBSET_DIFF:   y = y - x;
                            default:
                            begin
                                t = x + y;
                                y = x - y;
                                x = t;
                            end
                        endcase
                        v[j ^ h] = x;
                        v[j]     = y;
                    end
                end
            end
        endfunction

        // transform, pointwise product, inverse, then queue all n outputs
        function void convolve_run();
            int     lg;
            int     n;
            int     k;
            xform_t fwd;
            xform_t inv;
            coeff_t c;
            lg = eff_log();
            n  = 1 << lg;
            case (mode)
                MODE_AND:
                begin
                    fwd = SUPERSET_SUM;
                    inv = SUPERSET_DIFF;
                end
                MODE_OR:
                begin
                    fwd = SUBSET_SUM;
                    inv = SUBSET_DIFF;
                end
                default:
                begin
                    fwd = HADAMARD;
                    inv = HADAMARD;
                end
            endcase
            transform(a_work, n, fwd);
            transform(b_work, n, fwd);
            for (k = 0; k < n; k++)
                a_work[k] = a_work[k] * b_work[k];
            transform(a_work, n, inv);
            // xor inverse divides exactly by n
            if (fwd == HADAMARD)
            begin
                for (k = 0; k < n; k++)
                    a_work[k] = $signed(a_work[k]) >>> lg;
            end
            for (k = 0; k < n; k++)
            begin
                c.value = a_work[k][RES_W-1:0];
                c.index = MAX_LOG'(k);
                c.last  = (k == n - 1);
                expected_coeffs.push_back(c);
            end
        endfunction

        // accepted input transfer: store the pair, compute when the run completes
        function void note_pair(logic [ELEM_W-1:0] a, logic [ELEM_W-1:0] b);
            a_work[loaded] = {{(64 - ELEM_W){a[ELEM_W-1]}}, a};
            b_work[loaded] = {{(64 - ELEM_W){b[ELEM_W-1]}}, b};
            loaded++;
            if (loaded >= run_length())
            begin
                loaded = 0;
                convolve_run();
            end
        endfunction

        task report(string text);
            $display("[%0t] mismatch: %s", $realtime, text);
            mismatches++;
        endtask

        // accepted output transfer against the oldest expectation
        task check_result(logic [RES_W-1:0] value, logic [MAX_LOG-1:0] index,
                          logic last);
            coeff_t c;
            if (expected_coeffs.size() == 0)
            begin
                report($sformatf("unexpected result index %0d value %0d",
                                 index, $signed(value)));
            end
            else
            begin
                c = expected_coeffs.pop_front();
                if (value !== c.value)
                    report($sformatf("index %0d value %0d, expected %0d", c.index,
                                     $signed(value), $signed(c.value)));
                if (index !== c.index)
                    report($sformatf("result_index %0d, expected %0d", index, c.index));
                if (last !== c.last)
                    report($sformatf("index %0d last_flag %b, expected %b", c.index,
                                     last, c.last));
            end
        endtask
    endclass

endpackage

// ----- test/tb_bitwise_and_or_xor_convolution.sv -----
`timescale 1ns / 1ps

module tb_bitwise_and_or_xor_convolution;
    import bwc_pkg::*;
    import conv_check_pkg::*;

    localparam int SETTLE_CYCLES  = 64;
    localparam int HOLD_CYCLES    = 3000;
    localparam int WATCHDOG_LIMIT = 20000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [PDATA_W-1:0] pwdata;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    int src_idle_pct;
    int snk_idle_pct;
    int hold_left;
    bit hold_armed;
    int quiet_cycles;

    conv_scoreboard coeff_board = new();

    bwc_in_if #(.ELEM_W(ELEM_WIDTH_DEF)) in_ch ();
    bwc_out_if #(.LOG_MAX(LOG_MAX_LEN_DEF)) out_ch ();

    bitwise_and_or_xor_convolution dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #10 clk = ~clk;

    // result side: random stalls, or a long hold-off once armed
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            out_ch.ready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else if (hold_armed)
        begin
            out_ch.ready <= 1'b0;
            hold_left  = HOLD_CYCLES - 1;
            hold_armed = 1'b0;
        end
        else
        begin
            out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    // check every output transfer
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid === 1'b1 && out_ch.ready)
            coeff_board.check_result(out_ch.result_value, out_ch.result_index,
                                     out_ch.last_flag);
    end

    // watchdog on cycles without any transfer
    always @(posedge clk)
    begin
        if ((in_ch.valid === 1'b1 && in_ch.ready === 1'b1) ||
            (out_ch.valid === 1'b1 && out_ch.ready === 1'b1))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles = quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // one input transfer, with a random gap before it; valid stays up afterwards
    task automatic send_pair(input logic [ELEM_W-1:0] a, input logic [ELEM_W-1:0] b);
        while ($urandom_range(99) < src_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            @(negedge clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.a_elem <= a;
        in_ch.b_elem <= b;
        do
            @(posedge clk);
        while (in_ch.ready !== 1'b1);
        coeff_board.note_pair(a, b);
        @(negedge clk);
    endtask

    // stop sending and let every expected output arrive
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (coeff_board.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apb_write(input logic reg_sel, input logic [PDATA_W-1:0] value);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_sel, 2'b00};
        pwdata  <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        coeff_board.write_register(reg_sel, value);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic write_reg_idle(input logic reg_sel, input logic [PDATA_W-1:0] value);
        wait_drained();
        apb_write(reg_sel, value);
    endtask

    // element values leaning toward the extremes
    function automatic logic [ELEM_W-1:0] rand_elem();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            4:       return ELEM_W'($urandom_range(16)) - ELEM_W'(8);
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    // mostly short runs, a few at full length, now and then the clamped code
    function automatic int pick_log();
        int pick;
        pick = $urandom_range(11);
        if (pick <= 5)
            return $urandom_range(3);
        else if (pick <= 8)
            return $urandom_range(5, 4);
        else if (pick <= 10)
            return 6;
        else
            return 7;
    endfunction

    task automatic directed_cases();
        // length one: each pair is a whole run
        write_reg_idle(REG_LOG_LEN, 0);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_AND));
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7fff, 16'h8000);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_OR));
        send_pair(16'hffff, 16'h7fff);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_XOR));
        send_pair(16'h8000, 16'h7fff);
        // unused mode code behaves as xor
        write_reg_idle(REG_OP_MODE, 3);
        send_pair(16'h8000, 16'h8000);

        // length four in every mode with extreme elements
        write_reg_idle(REG_LOG_LEN, 2);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_AND));
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h7fff, 16'h7fff);
        send_pair(16'h8000, 16'h7fff);
        send_pair(16'h0000, 16'hffff);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_OR));
        send_pair(16'h7fff, 16'h8000);
        send_pair(16'hffff, 16'h0001);
        send_pair(16'h8000, 16'h8000);
        send_pair(16'h0000, 16'h7fff);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_XOR));
        repeat (4) send_pair(16'h8000, 16'h8000);

        // length write in the middle of a run restarts loading
        send_pair(16'h1234, 16'hedcb);
        send_pair(16'h7fff, 16'h8000);
        write_reg_idle(REG_LOG_LEN, 1);
        send_pair(16'h8000, 16'h7fff);
        send_pair(16'hffff, 16'hffff);

        // mode write mid-run: the mode at the last pair is used
        send_pair(16'h0101, 16'h8000);
        write_reg_idle(REG_OP_MODE, PDATA_W'(MODE_AND));
        send_pair(16'h7fff, 16'h00ff);
    endtask

    // random configurations, mostly complete runs, some cut short
    task automatic random_phase(input int item_goal);
        int sent;
        int n;
        int count;
        sent = 0;
        while (sent < item_goal)
        begin
            write_reg_idle(REG_OP_MODE, PDATA_W'($urandom_range(3)));
            if ($urandom_range(3) != 0)
                write_reg_idle(REG_LOG_LEN, PDATA_W'(pick_log()));
            n     = coeff_board.run_length();
            count = (n <= 8) ? n * int'($urandom_range(4, 1)) : n;
            if (n > 1 && $urandom_range(5) == 0)
                count += $urandom_range(n - 1, 1);
            repeat (count) send_pair(rand_elem(), rand_elem());
            sent += count;
        end
    endtask

    initial
    begin
        rst_n        = 1'b0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        in_ch.valid  = 1'b0;
        in_ch.a_elem = '0;
        in_ch.b_elem = '0;
        out_ch.ready = 1'b0;
        hold_left    = 0;
        hold_armed   = 1'b0;
        quiet_cycles = 0;
        src_idle_pct = 13;
        snk_idle_pct = 48;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        directed_cases();
        random_phase(130);

        wait_drained();
        src_idle_pct = 48;
        snk_idle_pct = 13;
        random_phase(130);

        // full-length runs against a long output stall, no idling on either side
        wait_drained();
        src_idle_pct = 0;
        snk_idle_pct = 0;
        write_reg_idle(REG_OP_MODE, PDATA_W'($urandom_range(3)));
        write_reg_idle(REG_LOG_LEN, 7);
        @(posedge clk);
        hold_armed = 1'b1;
        @(negedge clk);
        repeat (128) send_pair(rand_elem(), rand_elem());
        random_phase(30);

        wait_drained();
        if (coeff_board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/bwc_pkg.sv
rtl/core/bwc_if.sv
rtl/core/bwc_alu.sv
rtl/core/bwc_core.sv
rtl/core/bitwise_and_or_xor_convolution.sv
test/conv_check_pkg.sv
test/tb_bitwise_and_or_xor_convolution.sv
